### sv/plane_point_line_query_top_macros.svh
// Assertion helpers for the plane query block.
`ifndef PLANE_POINT_LINE_QUERY_TOP_MACROS_SVH
`define PLANE_POINT_LINE_QUERY_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PPLQ_ASSERT_SAME(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("pplq: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define PPLQ_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("pplq: next-cycle check failed");

`endif

### sv/pplq_pkg.sv
`default_nettype none
package pplq_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int COORD_W       = 32;
  localparam int NRM_W         = 18;
  localparam int OFS_W         = 32;
  localparam int EPS_W         = 16;
  localparam int CMD_W         = 3;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 32;
  // three 32x18 products summed without loss
  localparam int SUM_W         = 51;
  // quotient bits kept by the divider
  localparam int Q_W           = 32;

  localparam logic signed [NRM_W-1:0] NRM_X_RST = 18'sd0;
  localparam logic signed [NRM_W-1:0] NRM_Y_RST = 18'sd0;
  localparam logic signed [NRM_W-1:0] NRM_Z_RST = 18'sd65536;
  localparam logic signed [OFS_W-1:0] OFS_RST   = 32'sd0;
  localparam logic [EPS_W-1:0]        EPS_RST   = 16'd1;

  typedef enum logic [CMD_W-1:0] {
    CMD_DIST    = 3'd0,
    CMD_FRONT   = 3'd1,
    CMD_MIRROR  = 3'd2,
    CMD_LINE    = 3'd3,
    CMD_SEGMENT = 3'd4
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NORMAL_X    = 3'd0,
    REG_NORMAL_Y    = 3'd1,
    REG_NORMAL_Z    = 3'd2,
    REG_PLANE_OFS   = 3'd3,
    REG_PARALLEL_EPS = 3'd4
  } reg_e;

  typedef struct packed {
    logic [CMD_W-1:0]          cmd;
    logic signed [COORD_W-1:0] point_a_x;
    logic signed [COORD_W-1:0] point_a_y;
    logic signed [COORD_W-1:0] point_a_z;
    logic signed [COORD_W-1:0] point_b_x;
    logic signed [COORD_W-1:0] point_b_y;
    logic signed [COORD_W-1:0] point_b_z;
  } query_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic signed [COORD_W-1:0] out_z;
    logic signed [COORD_W-1:0] scalar_value;
    logic                      valid_hit;
  } result_t;

endpackage
`default_nettype wire

### sv/pplq_stream_if.sv
`default_nettype none
interface pplq_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### sv/plane_point_line_query_top.sv
// Plane query unit, Q(FRAC_BITS) fixed point.
// Channels: query (sink, query_t beats: cmd plus vectors a and b)
// and result (source: out xyz, scalar_value, valid_hit). One result beat
// per query beat, in order. Plane registers are written through the plain
// port cfg_we / cfg_index / cfg_wdata, by the user only while the unit is
// drained; the block does not enforce this. Throughput: one beat per
// cycle, sustained while the skid is not full. Depth: 39 register stages.
// Two stages for the dot products, one for the offset add and parallel
// test, one divider load (operand setup), 32 restoring-division stages
// (one quotient bit each, this chain sets the depth), then operand select,
// multiply, and the add/saturate that lands in the output register.
// Reset (rst, synchronous): all stage valids clear, the plane returns to
// n = (0, 0, 1.0), d = 0, threshold 1.
// Receiver stall: result is a two-entry buffer (output register plus skid).
// When the skid fills, query.ready drops and the whole pipeline holds;
// query.ready is a register output and never depends on result.ready.
`default_nettype none
`include "plane_point_line_query_top_macros.svh"
module plane_point_line_query_top
  import pplq_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  pplq_stream_if.sink           query,
  pplq_stream_if.source         result
);

  localparam int DOT_W = SUM_W - FRAC_BITS;
  localparam int DA_W  = ((DOT_W > OFS_W) ? DOT_W : OFS_W) + 1;
  localparam int DEN_W = DA_W + 1;
  localparam int NUM_W = DA_W + FRAC_BITS;
  localparam int HI_W  = NUM_W - Q_W;
  localparam int X_W   = (DA_W + 1 > COORD_W + 1) ? DA_W + 1 : COORD_W + 1;
  localparam int P_W   = X_W + Q_W;
  localparam int R_W   = P_W + 1;
  localparam int PRD_W = COORD_W + NRM_W;

  localparam logic signed [R_W-1:0] SAT_MAX = R_W'({1'b0, {(Q_W-1){1'b1}}});
  localparam logic signed [R_W-1:0] SAT_MIN = ~SAT_MAX;
  localparam logic [Q_W-1:0] T_POS_MAX = {1'b0, {(Q_W-1){1'b1}}};
  localparam logic [Q_W-1:0] T_NEG_MAX = {1'b1, {(Q_W-1){1'b0}}};

  typedef enum logic [1:0] {
    KIND_ZERO,
    KIND_A,
    KIND_B,
    KIND_MUL
  } kind_e;

  typedef struct packed {
    logic [CMD_W-1:0]            cmd;
    logic [2:0][COORD_W-1:0]     a;
    logic [2:0][COORD_W-1:0]     b;
    logic [DA_W-1:0]             da;
    logic [Q_W-1:0]              scalar;
    logic                        vh;
    kind_e                       kind;
    logic                        qneg;
  } pay_t;

  function automatic logic [Q_W-1:0] sat_q(input logic signed [R_W-1:0] v);
    if (v > SAT_MAX) return SAT_MAX[Q_W-1:0];
    else if (v < SAT_MIN) return SAT_MIN[Q_W-1:0];
    else return v[Q_W-1:0];
  endfunction

  // ---------------- plane registers ----------------
  logic signed [NRM_W-1:0] nrm [3];
  logic signed [OFS_W-1:0] ofs;
  logic [EPS_W-1:0]        eps;

  always_ff @(posedge clk) begin
    if (rst) begin
      nrm[0] <= NRM_X_RST;
      nrm[1] <= NRM_Y_RST;
      nrm[2] <= NRM_Z_RST;
      ofs    <= OFS_RST;
      eps    <= EPS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NORMAL_X:     nrm[0] <= cfg_wdata[NRM_W-1:0];
        REG_NORMAL_Y:     nrm[1] <= cfg_wdata[NRM_W-1:0];
        REG_NORMAL_Z:     nrm[2] <= cfg_wdata[NRM_W-1:0];
        REG_PLANE_OFS:    ofs    <= cfg_wdata[OFS_W-1:0];
        REG_PARALLEL_EPS: eps    <= cfg_wdata[EPS_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- flow control ----------------
  // Whole pipeline advances together; it holds only while the skid is full.
  logic skid_v;
  logic out_v;
  logic en;

  assign en          = !skid_v;
  assign query.ready = en;

  // ---------------- S1: products with the normal ----------------
  logic                    s1_v;
  query_t                  s1_q;
  logic signed [PRD_W-1:0] s1_pa [3];
  logic signed [PRD_W-1:0] s1_pb [3];

  always_ff @(posedge clk) begin
    if (rst) s1_v <= 1'b0;
    else if (en) s1_v <= query.valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_q     <= query.data;
      s1_pa[0] <= query.data.point_a_x * nrm[0];
      s1_pa[1] <= query.data.point_a_y * nrm[1];
      s1_pa[2] <= query.data.point_a_z * nrm[2];
      s1_pb[0] <= query.data.point_b_x * nrm[0];
      s1_pb[1] <= query.data.point_b_y * nrm[1];
      s1_pb[2] <= query.data.point_b_z * nrm[2];
    end
  end

  // ---------------- S2: dot products, floor shift ----------------
  logic signed [SUM_W-1:0] sum_a;
  logic signed [SUM_W-1:0] sum_b;
  logic                    s2_v;
  query_t                  s2_q;
  logic signed [DOT_W-1:0] s2_dota;
  logic signed [DOT_W-1:0] s2_dotb;

  assign sum_a = SUM_W'(s1_pa[0]) + SUM_W'(s1_pa[1]) + SUM_W'(s1_pa[2]);
  assign sum_b = SUM_W'(s1_pb[0]) + SUM_W'(s1_pb[1]) + SUM_W'(s1_pb[2]);

  always_ff @(posedge clk) begin
    if (rst) s2_v <= 1'b0;
    else if (en) s2_v <= s1_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_q    <= s1_q;
      s2_dota <= DOT_W'(sum_a >>> FRAC_BITS);
      s2_dotb <= DOT_W'(sum_b >>> FRAC_BITS);
    end
  end

  // ---------------- S3: add offset, parallel test ----------------
  logic [DOT_W-1:0]        kabs;
  logic                    s3_v;
  query_t                  s3_q;
  logic signed [DOT_W-1:0] s3_dota;
  logic signed [DA_W-1:0]  s3_da;
  logic signed [DA_W-1:0]  s3_db;
  logic [DOT_W-1:0]        s3_kabs;
  logic                    s3_kneg;
  logic                    s3_par;

  assign kabs = s2_dotb[DOT_W-1] ? DOT_W'(-s2_dotb) : DOT_W'(s2_dotb);

  always_ff @(posedge clk) begin
    if (rst) s3_v <= 1'b0;
    else if (en) s3_v <= s2_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_q    <= s2_q;
      s3_dota <= s2_dota;
      s3_da   <= DA_W'(s2_dota) + DA_W'(ofs);
      s3_db   <= DA_W'(s2_dotb) + DA_W'(ofs);
      s3_kabs <= kabs;
      s3_kneg <= s2_dotb[DOT_W-1];
      // zero direction is parallel even with a zero threshold
      s3_par  <= (s2_dotb == '0) || (kabs < DOT_W'(eps));
    end
  end

  // ---------------- S4: command decode, divider operands ----------------
  logic [DA_W-1:0]         daabs;
  logic signed [DEN_W-1:0] diff;
  logic [DEN_W-1:0]        diffabs;
  logic [NUM_W-1:0]        num;
  logic [DEN_W-1:0]        den;
  logic                    da_pos;
  logic                    da_neg;
  logic                    db_pos;
  logic                    db_neg;
  logic [Q_W-1:0]          sc_da;
  pay_t                    pay4;

  assign da_neg  = s3_da[DA_W-1];
  assign da_pos  = !da_neg && (s3_da != '0);
  assign db_neg  = s3_db[DA_W-1];
  assign db_pos  = !db_neg && (s3_db != '0);
  assign daabs   = da_neg ? DA_W'(-s3_da) : DA_W'(s3_da);
  assign diff    = DEN_W'(s3_da) - DEN_W'(s3_db);
  assign diffabs = diff[DEN_W-1] ? DEN_W'(-diff) : DEN_W'(diff);
  assign num     = {daabs, {FRAC_BITS{1'b0}}};
  assign sc_da   = sat_q(R_W'(s3_da));

  always_comb begin
    pay4.cmd    = s3_q.cmd;
    pay4.a[0]   = s3_q.point_a_x;
    pay4.a[1]   = s3_q.point_a_y;
    pay4.a[2]   = s3_q.point_a_z;
    pay4.b[0]   = s3_q.point_b_x;
    pay4.b[1]   = s3_q.point_b_y;
    pay4.b[2]   = s3_q.point_b_z;
    pay4.da     = s3_da;
    pay4.scalar = sc_da;
    pay4.vh     = 1'b0;
    pay4.kind   = KIND_ZERO;
    pay4.qneg   = da_neg ^ diff[DEN_W-1];
    den         = diffabs;
    unique case (s3_q.cmd)
      CMD_DIST: pay4.vh = 1'b1;
      CMD_FRONT: begin
        pay4.scalar = sat_q(R_W'(s3_dota));
        pay4.vh     = s3_dota[DOT_W-1];
      end
      CMD_MIRROR: begin
        pay4.vh   = 1'b1;
        pay4.kind = KIND_MUL;
      end
      CMD_LINE: begin
        den       = DEN_W'(s3_kabs);
        pay4.qneg = da_neg ^ s3_kneg;
        pay4.vh   = !s3_par;
        pay4.kind = s3_par ? KIND_ZERO : KIND_MUL;
      end
      CMD_SEGMENT: begin
        if ((da_pos && db_pos) || (da_neg && db_neg)) begin
          pay4.vh = 1'b0;
        end else begin
          pay4.vh = 1'b1;
          if (s3_da == '0) pay4.kind = KIND_A;
          else if (s3_db == '0) pay4.kind = KIND_B;
          else pay4.kind = KIND_MUL;
        end
      end
      default: pay4.scalar = '0;
    endcase
  end

  // ---------------- divider: load stage plus one stage per quotient bit ----------------
  logic             d_v   [Q_W+1];
  logic [DEN_W-1:0] d_rem [Q_W+1];
  logic [Q_W-1:0]   d_lo  [Q_W+1];
  logic [Q_W-1:0]   d_q   [Q_W+1];
  logic [DEN_W-1:0] d_den [Q_W+1];
  logic             d_ovf [Q_W+1];
  pay_t             d_pay [Q_W+1];

  always_ff @(posedge clk) begin
    if (rst) d_v[0] <= 1'b0;
    else if (en) d_v[0] <= s3_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_rem[0] <= DEN_W'(num[NUM_W-1 -: HI_W]);
      d_lo[0]  <= num[Q_W-1:0];
      d_q[0]   <= '0;
      d_den[0] <= den;
      d_ovf[0] <= 1'b0;
      d_pay[0] <= pay4;
    end
  end

  for (genvar j = 1; j <= Q_W; j++) begin : g_div
    logic [DEN_W:0] trial;
    logic           ge;

    assign trial = {d_rem[j-1], d_lo[j-1][Q_W-1]};
    assign ge    = trial >= {1'b0, d_den[j-1]};

    always_ff @(posedge clk) begin
      if (rst) d_v[j] <= 1'b0;
      else if (en) d_v[j] <= d_v[j-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        d_rem[j] <= ge ? DEN_W'(trial - {1'b0, d_den[j-1]}) : DEN_W'(trial);
        d_lo[j]  <= d_lo[j-1] << 1;
        d_q[j]   <= {d_q[j-1][Q_W-2:0], ge};
        d_den[j] <= d_den[j-1];
        d_pay[j] <= d_pay[j-1];
        // quotient of 2^Q_W or more: remainder head already reaches the divisor
        if (j == 1) d_ovf[j] <= d_rem[j-1] >= d_den[j-1];
        else d_ovf[j] <= d_ovf[j-1];
      end
    end
  end

  // ---------------- T: saturate quotient, pick multiplier operands ----------------
  pay_t                    dp;
  logic [Q_W-1:0]          dq;
  logic [Q_W-1:0]          tq;
  logic signed [X_W-1:0]   x_sel [3];
  logic signed [Q_W-1:0]   y_sel [3];
  logic                    t_v;
  pay_t                    t_pay;
  logic                    t_add;
  logic signed [X_W-1:0]   t_x [3];
  logic signed [Q_W-1:0]   t_y [3];

  assign dp = d_pay[Q_W];
  assign dq = d_q[Q_W];

  always_comb begin
    if (!dp.qneg) tq = (d_ovf[Q_W] || dq[Q_W-1]) ? T_POS_MAX : dq;
    else tq = (d_ovf[Q_W] || dq > T_NEG_MAX) ? T_NEG_MAX : Q_W'(-dq);
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      unique case (dp.cmd)
        CMD_MIRROR: begin
          x_sel[i] = X_W'($signed({dp.da, 1'b0}));
          y_sel[i] = Q_W'(nrm[i]);
        end
        CMD_SEGMENT: begin
          x_sel[i] = X_W'($signed(dp.b[i])) - X_W'($signed(dp.a[i]));
          y_sel[i] = tq;
        end
        default: begin
          x_sel[i] = X_W'($signed(dp.b[i]));
          y_sel[i] = tq;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) t_v <= 1'b0;
    else if (en) t_v <= d_v[Q_W];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_pay <= dp;
      t_add <= (dp.cmd == CMD_SEGMENT);
      for (int i = 0; i < 3; i++) begin
        t_x[i] <= x_sel[i];
        t_y[i] <= y_sel[i];
      end
    end
  end

  // ---------------- M: multiply ----------------
  logic                  m_v;
  pay_t                  m_pay;
  logic                  m_add;
  logic signed [P_W-1:0] m_p [3];

  always_ff @(posedge clk) begin
    if (rst) m_v <= 1'b0;
    else if (en) m_v <= t_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_pay <= t_pay;
      m_add <= t_add;
      for (int i = 0; i < 3; i++) m_p[i] <= t_x[i] * t_y[i];
    end
  end

  // ---------------- R: floor shift, add, saturate into output buffer ----------------
  logic signed [R_W-1:0] sh  [3];
  logic signed [R_W-1:0] rsum [3];
  logic [Q_W-1:0]        rpt [3];
  result_t               new_item;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sh[i]   = R_W'(m_p[i] >>> FRAC_BITS);
      rsum[i] = m_add ? R_W'($signed(m_pay.a[i])) + sh[i]
                      : R_W'($signed(m_pay.a[i])) - sh[i];
      unique case (m_pay.kind)
        KIND_ZERO: rpt[i] = '0;
        KIND_A:    rpt[i] = m_pay.a[i];
        KIND_B:    rpt[i] = m_pay.b[i];
        KIND_MUL:  rpt[i] = sat_q(rsum[i]);
        default:   rpt[i] = '0;
      endcase
    end
    new_item.out_x        = rpt[0];
    new_item.out_y        = rpt[1];
    new_item.out_z        = rpt[2];
    new_item.scalar_value = m_pay.scalar;
    new_item.valid_hit    = m_pay.vh;
  end

  // Output register plus skid entry.
  result_t out_item;
  result_t skid_item;
  logic    inc;
  logic    take;

  assign inc  = m_v && en;
  assign take = out_v && result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else begin
      if (inc) begin
        if (!out_v || take) begin
          out_v <= 1'b1;
        end else begin
          skid_v <= 1'b1;
        end
      end else if (take) begin
        if (skid_v) skid_v <= 1'b0;
        else out_v <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (inc) begin
      if (!out_v || take) out_item <= new_item;
      else skid_item <= new_item;
    end else if (take && skid_v) begin
      out_item <= skid_item;
    end
  end

  assign result.valid = out_v;
  assign result.data  = out_item;

  // ---------------- checks ----------------
  `PPLQ_ASSERT_SAME(a_skid_has_out, clk, rst, skid_v, out_v)
  `PPLQ_ASSERT_NEXT(a_stall_fills_skid, clk, rst, inc && out_v && !result.ready, skid_v)
  `PPLQ_ASSERT_NEXT(a_skid_holds, clk, rst, skid_v && !result.ready, skid_v && out_v)

endmodule
`default_nettype wire

### tb/testbench.sv
`default_nettype none
module testbench;
  import pplq_pkg::*;

  // Pipeline depth bound, above the block header's stage count; the drain wait covers it with margin.
  localparam int PIPE_DEPTH = 40;
  localparam int MAX_CYCLES = 400000;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  pplq_stream_if #(.T(query_t))  query_ch ();
  pplq_stream_if #(.T(result_t)) result_ch ();

  plane_point_line_query_top u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .query     (query_ch.sink),
    .result    (result_ch.source)
  );

  // Local copy of the plane registers, kept in step with every write.
  logic signed [NRM_W-1:0] plane_nx, plane_ny, plane_nz;
  logic signed [OFS_W-1:0] plane_d;
  logic [EPS_W-1:0]        plane_eps;

  result_t   expected_hits[$];
  int        error_count;
  longint    cycle_count;
  bit        recv_stall_on;
  bit        recv_burst_mode;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Floor shift by the fraction width.
  function automatic longint floor_q(longint x);
    return x >>> FRAC_BITS_DEF;
  endfunction

  function automatic longint clamp32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // Dot product with the plane normal; three 32x18 products fit easily in 64 bits.
  function automatic longint dot_normal(longint vx, longint vy, longint vz);
    return floor_q(vx * longint'(plane_nx) + vy * longint'(plane_ny) +
                   vz * longint'(plane_nz));
  endfunction

  function automatic result_t predict_query(query_t q);
    result_t r;
    longint a[3], b[3], n[3], o[3];
    longint dot_a, dist_a, scal, k, mag, t, dist_b;
    logic   hit;
    a[0] = q.point_a_x; a[1] = q.point_a_y; a[2] = q.point_a_z;
    b[0] = q.point_b_x; b[1] = q.point_b_y; b[2] = q.point_b_z;
    n[0] = plane_nx; n[1] = plane_ny; n[2] = plane_nz;
    o[0] = 0; o[1] = 0; o[2] = 0;
    hit = 1'b0;
    scal = 0;
    dot_a = dot_normal(a[0], a[1], a[2]);
    dist_a = dot_a + longint'(plane_d);
    case (q.cmd)
      CMD_DIST: begin
        scal = dist_a;
        hit = 1'b1;
      end
      CMD_FRONT: begin
        scal = dot_a;
        hit = dot_a < 0;
      end
      CMD_MIRROR: begin
        scal = dist_a;
        for (int i = 0; i < 3; i++) o[i] = a[i] - floor_q(2 * dist_a * n[i]);
        hit = 1'b1;
      end
      CMD_LINE: begin
        scal = dist_a;
        k = dot_normal(b[0], b[1], b[2]);
        mag = (k < 0) ? -k : k;
        // Parallel: k zero, or below the threshold.
        if (k != 0 && mag >= longint'({1'b0, plane_eps})) begin
          t = clamp32((dist_a <<< FRAC_BITS_DEF) / k);
          for (int i = 0; i < 3; i++) o[i] = a[i] - floor_q(b[i] * t);
          hit = 1'b1;
        end
      end
      CMD_SEGMENT: begin
        scal = dist_a;
        dist_b = dot_normal(b[0], b[1], b[2]) + longint'(plane_d);
        if (!((dist_a > 0 && dist_b > 0) || (dist_a < 0 && dist_b < 0))) begin
          hit = 1'b1;
          if (dist_a == 0) begin
            for (int i = 0; i < 3; i++) o[i] = a[i];
          end else if (dist_b == 0) begin
            for (int i = 0; i < 3; i++) o[i] = b[i];
          end else begin
            t = (dist_a <<< FRAC_BITS_DEF) / (dist_a - dist_b);
            for (int i = 0; i < 3; i++) o[i] = a[i] + floor_q((b[i] - a[i]) * t);
          end
        end
      end
      default: ;
    endcase
    r.out_x        = clamp32(o[0]);
    r.out_y        = clamp32(o[1]);
    r.out_z        = clamp32(o[2]);
    r.scalar_value = clamp32(scal);
    r.valid_hit    = hit;
    return r;
  endfunction

  // Receiver stall pattern: alternates between long open stretches and choppy ones.
  always @(negedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if ($urandom_range(0, 63) == 0) recv_burst_mode = ~recv_burst_mode;
      if (recv_burst_mode) recv_stall_on = 1'b0;
      else recv_stall_on = ($urandom_range(0, 2) == 0);
      result_ch.ready <= ~recv_stall_on;
    end
  end

  // Result checker: sample at the rising edge, compare with the oldest prediction.
  always @(posedge clk) begin
    result_t got, want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      got = result_ch.data;
      if (expected_hits.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result beat %h", $time, got);
      end else begin
        want = expected_hits.pop_front();
        if (got.out_x !== want.out_x) begin
          error_count++;
          $display("%0t: out_x exp %0d got %0d", $time, want.out_x, got.out_x);
        end
        if (got.out_y !== want.out_y) begin
          error_count++;
          $display("%0t: out_y exp %0d got %0d", $time, want.out_y, got.out_y);
        end
        if (got.out_z !== want.out_z) begin
          error_count++;
          $display("%0t: out_z exp %0d got %0d", $time, want.out_z, got.out_z);
        end
        if (got.scalar_value !== want.scalar_value) begin
          error_count++;
          $display("%0t: scalar_value exp %0d got %0d", $time,
                   want.scalar_value, got.scalar_value);
        end
        if (got.valid_hit !== want.valid_hit) begin
          error_count++;
          $display("%0t: valid_hit exp %0b got %0b", $time,
                   want.valid_hit, got.valid_hit);
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > MAX_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Send one beat; valid is held across back-to-back beats.
  task automatic send_query(query_t q);
    query_ch.valid <= 1'b1;
    query_ch.data  <= q;
    @(posedge clk);
    while (!query_ch.ready) @(posedge clk);
    expected_hits.push_back(predict_query(q));
    @(negedge clk);
  endtask

  task automatic idle_sender(int cycles);
    query_ch.valid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // Wait for every prediction to be matched, then let the pipe settle.
  task automatic drain_results();
    query_ch.valid <= 1'b0;
    while (expected_hits.size() != 0) @(negedge clk);
    repeat (PIPE_DEPTH + 8) @(negedge clk);
  endtask

  task automatic write_reg(reg_e idx, logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_NORMAL_X:     plane_nx  = value[NRM_W-1:0];
      REG_NORMAL_Y:     plane_ny  = value[NRM_W-1:0];
      REG_NORMAL_Z:     plane_nz  = value[NRM_W-1:0];
      REG_PLANE_OFS:    plane_d   = value[OFS_W-1:0];
      REG_PARALLEL_EPS: plane_eps = value[EPS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_plane(int nx, int ny, int nz, int d, int eps);
    write_reg(REG_NORMAL_X, nx);
    write_reg(REG_NORMAL_Y, ny);
    write_reg(REG_NORMAL_Z, nz);
    write_reg(REG_PLANE_OFS, d);
    write_reg(REG_PARALLEL_EPS, eps);
  endtask

  function automatic query_t make_query(logic [CMD_W-1:0] c, int ax, int ay, int az,
                                        int bx, int by, int bz);
    query_t q;
    q.cmd = c;
    q.point_a_x = ax; q.point_a_y = ay; q.point_a_z = az;
    q.point_b_x = bx; q.point_b_y = by; q.point_b_z = bz;
    return q;
  endfunction

  // Coordinates: mostly moderate, sometimes full range or extremes.
  function automatic int rand_coord();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return ($urandom_range(0, 1) != 0) ? 32'h7fffffff : 32'h80000000;
      2: return 0;
      default: return $signed($urandom_range(0, 32'h00ffffff)) - 32'sh00800000;
    endcase
  endfunction

  function automatic int rand_normal_comp();
    case ($urandom_range(0, 5))
      0: return 65536;
      1: return -65536;
      2: return 0;
      default: return $signed($urandom_range(0, 131072)) - 65536;
    endcase
  endfunction

  // Directed: reset plane (z = 0), every command, extremes and special cases.
  task automatic test_directed_reset_plane();
    // distance, front facing on both sides, mirror
    send_query(make_query(CMD_DIST, 0, 0, 32'h00030000, 0, 0, 0));
    send_query(make_query(CMD_FRONT, 0, 0, -32'sh00010000, 0, 0, 0));
    send_query(make_query(CMD_FRONT, 0, 0, 32'h00010000, 0, 0, 0));
    send_query(make_query(CMD_MIRROR, 5, 7, 32'h7fffffff, 0, 0, 0));
    send_query(make_query(CMD_MIRROR, 32'h80000000, 32'h7fffffff, 32'h80000000, 0, 0, 0));
    // line: normal hit, parallel (k = 0), saturating quotient
    send_query(make_query(CMD_LINE, 1, 2, 32'h00050000, 3, 4, -32'sh00010000));
    send_query(make_query(CMD_LINE, 1, 2, 32'h00050000, 32'h00010000, 0, 0));
    send_query(make_query(CMD_LINE, 32'h7fffffff, 0, 32'h7fffffff, 32'h7fffffff, 0, 1));
    // segment: same side, endpoint a on plane, endpoint b on plane, crossing
    send_query(make_query(CMD_SEGMENT, 0, 0, 32'h00010000, 0, 0, 32'h00020000));
    send_query(make_query(CMD_SEGMENT, 9, 9, 0, 1, 1, 32'h00020000));
    send_query(make_query(CMD_SEGMENT, 9, 9, 32'h00020000, 1, 1, 0));
    send_query(make_query(CMD_SEGMENT, 32'h80000000, 32'h7fffffff, -32'sh00010000,
                          32'h7fffffff, 32'h80000000, 32'h00030000));
    // unused command codes
    send_query(make_query(3'd5, 1, 2, 3, 4, 5, 6));
    send_query(make_query(3'd7, -1, -1, -1, -1, -1, -1));
    drain_results();
  endtask

  // Directed: extreme plane, zero threshold, max threshold.
  task automatic test_directed_extreme_plane();
    set_plane(-65536, 65536, -65536, 32'h7fffffff, 0);
    send_query(make_query(CMD_DIST, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 0, 0, 0));
    send_query(make_query(CMD_MIRROR, 32'h7fffffff, 32'h80000000, 0, 0, 0, 0));
    // zero threshold: tiny k still intersects
    send_query(make_query(CMD_LINE, 0, 0, 0, 1, 0, 0));
    send_query(make_query(CMD_LINE, 0, 0, 0, 1, 1, 0));
    drain_results();
    set_plane(65536, 0, 0, 32'h80000000, 65535);
    send_query(make_query(CMD_LINE, 0, 0, 0, 32'h0000fffe, 0, 0));
    send_query(make_query(CMD_LINE, 0, 0, 0, 32'h0000ffff, 0, 0));
    send_query(make_query(CMD_SEGMENT, 32'h80000000, 0, 0, 32'h7fffffff, 0, 0));
    send_query(make_query(CMD_FRONT, 32'h80000000, 0, 0, 0, 0, 0));
    drain_results();
  endtask

  // Random: bursts and gaps from the sender, several plane settings.
  task automatic test_random_queries(int total);
    int sent;
    int burst;
    query_t q;
    sent = 0;
    while (sent < total) begin
      if (sent % 100 == 0) begin
        drain_results();
        set_plane(rand_normal_comp(), rand_normal_comp(), rand_normal_comp(),
                  ($urandom_range(0, 3) == 0) ? $urandom() :
                    $signed($urandom_range(0, 32'h00ffffff)) - 32'sh00800000,
                  ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) :
                    $urandom_range(0, 64));
      end
      burst = $urandom_range(1, 24);
      for (int i = 0; i < burst && sent < total; i++) begin
        q = make_query(($urandom_range(0, 15) == 0) ? $urandom_range(5, 7) :
                         $urandom_range(0, 4),
                       rand_coord(), rand_coord(), rand_coord(),
                       rand_coord(), rand_coord(), rand_coord());
        // Segments crossing the plane are kept common: set b to minus a.
        if (q.cmd == CMD_SEGMENT && $urandom_range(0, 1) != 0) begin
          q.point_b_x = -q.point_a_x;
          q.point_b_y = -q.point_a_y;
          q.point_b_z = -q.point_a_z;
        end
        send_query(q);
        sent++;
      end
      if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 12));
      // Hold off until the pipe is empty now and then.
      if (sent % 150 < burst) begin
        query_ch.valid <= 1'b0;
        while (expected_hits.size() != 0) @(negedge clk);
      end
    end
    drain_results();
  endtask

  initial begin
    error_count     = 0;
    cycle_count     = 0;
    recv_stall_on   = 1'b0;
    recv_burst_mode = 1'b0;
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_wdata       = '0;
    query_ch.valid  = 1'b0;
    query_ch.data   = '0;
    plane_nx  = NRM_X_RST;
    plane_ny  = NRM_Y_RST;
    plane_nz  = NRM_Z_RST;
    plane_d   = OFS_RST;
    plane_eps = EPS_RST;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed_reset_plane();
    test_directed_extreme_plane();
    test_random_queries(500);

    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire

### plane_point_line_query_top.f
+incdir+sv
sv/pplq_pkg.sv
sv/pplq_stream_if.sv
sv/plane_point_line_query_top.sv
tb/testbench.sv
